### design/gcf_pkg.sv
// gcf_pkg: shared types, constants and register codes for the genotype call filter
// used by every module under design/; no dependencies
`timescale 1ns / 1ps

package gcf_pkg;

   // largest number of individuals per site; sets the width of the called count
   localparam int MaxIndividuals = 4096;
   localparam int CountWidth     = $clog2(MaxIndividuals) + 1;
   localparam logic [CountWidth-1:0] COUNT_MAX = '1;

   localparam int ADDR_WIDTH = 5;
   localparam int DATA_WIDTH = 32;

   localparam int POST_WIDTH  = 17;
   localparam int COUNT_WIDTH = 16;
   localparam int DEPTH_WIDTH = 18;

   typedef enum logic [2:0] {
      REG_POST_CUTOFF     = 3'd0,
      REG_MIN_DEPTH       = 3'd1,
      REG_MAX_DEPTH       = 3'd2,
      REG_MIN_MM_FRACTION = 3'd3,
      REG_MIN_INDIVIDUALS = 3'd4
   } gcf_reg_type;

   localparam logic signed [2:0] GENO_HOM_MAJOR = 3'sd0;
   localparam logic signed [2:0] GENO_HET       = 3'sd1;
   localparam logic signed [2:0] GENO_HOM_MINOR = 3'sd2;
   localparam logic signed [2:0] GENO_NONE      = -3'sd1;

   // 1/3 in Q0.16
   localparam logic [16:0]        POST_CUTOFF_RESET = 17'd21845;
   localparam logic signed [18:0] DEPTH_OFF         = -19'sd1;
   localparam logic signed [17:0] FRACTION_OFF      = -18'sd1;

   typedef struct packed {
      logic [16:0]        post_cutoff;
      logic signed [18:0] min_depth;
      logic signed [18:0] max_depth;
      logic signed [17:0] min_mm_fraction;
      logic [15:0]        min_individuals;
   } gcf_cfg_type;

   typedef struct packed {
      logic [POST_WIDTH-1:0]  post_hom_major;
      logic [POST_WIDTH-1:0]  post_het;
      logic [POST_WIDTH-1:0]  post_hom_minor;
      logic [COUNT_WIDTH-1:0] count_a;
      logic [COUNT_WIDTH-1:0] count_c;
      logic [COUNT_WIDTH-1:0] count_g;
      logic [COUNT_WIDTH-1:0] count_t;
      logic [1:0]             major_base;
      logic [1:0]             minor_base;
      logic                   site_selected;
      logic                   last_individual;
   } gcf_item_type;

   typedef struct packed {
      logic signed [2:0] genotype;
      logic              called;
   } gcf_call_type;

endpackage

### design/gcf_csr.sv
// gcf_csr: apb-style register file holding the filter thresholds
// depends on gcf_pkg
`timescale 1ns / 1ps

module gcf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gcf_pkg::ADDR_WIDTH-1:0]    paddr,
   input  logic [gcf_pkg::DATA_WIDTH-1:0]    pwdata,
   output logic [gcf_pkg::DATA_WIDTH-1:0]    prdata,
   output logic                              pready,
   output gcf_pkg::gcf_cfg_type              cfg
);

   gcf_pkg::gcf_cfg_type cfg_ff, cfg_in;
   gcf_pkg::gcf_reg_type reg_sel;
   logic                 wr_en;

   assign reg_sel = gcf_pkg::gcf_reg_type'(paddr[4:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            gcf_pkg::REG_POST_CUTOFF:     cfg_in.post_cutoff     = pwdata[16:0];
            gcf_pkg::REG_MIN_DEPTH:       cfg_in.min_depth       = pwdata[18:0];
            gcf_pkg::REG_MAX_DEPTH:       cfg_in.max_depth       = pwdata[18:0];
            gcf_pkg::REG_MIN_MM_FRACTION: cfg_in.min_mm_fraction = pwdata[17:0];
            gcf_pkg::REG_MIN_INDIVIDUALS: cfg_in.min_individuals = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         gcf_pkg::REG_POST_CUTOFF:     prdata = {15'd0, cfg_ff.post_cutoff};
         gcf_pkg::REG_MIN_DEPTH:       prdata = 32'($signed(cfg_ff.min_depth));
         gcf_pkg::REG_MAX_DEPTH:       prdata = 32'($signed(cfg_ff.max_depth));
         gcf_pkg::REG_MIN_MM_FRACTION: prdata = 32'($signed(cfg_ff.min_mm_fraction));
         gcf_pkg::REG_MIN_INDIVIDUALS: prdata = {16'd0, cfg_ff.min_individuals};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.post_cutoff     <= gcf_pkg::POST_CUTOFF_RESET;
         cfg_ff.min_depth       <= gcf_pkg::DEPTH_OFF;
         cfg_ff.max_depth       <= gcf_pkg::DEPTH_OFF;
         cfg_ff.min_mm_fraction <= gcf_pkg::FRACTION_OFF;
         cfg_ff.min_individuals <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/gcf_call_unit.sv
// gcf_call_unit: maximum-posterior pick plus posterior, depth and fraction checks
// depends on gcf_pkg
`timescale 1ns / 1ps

module gcf_call_unit (
   input  gcf_pkg::gcf_item_type item,
   input  gcf_pkg::gcf_cfg_type  cfg,
   output gcf_pkg::gcf_call_type call
);

   logic [gcf_pkg::POST_WIDTH-1:0]  best_01, best;
   logic signed [2:0]               geno_01, geno;
   logic [gcf_pkg::COUNT_WIDTH-1:0] cnt [4];
   logic [gcf_pkg::DEPTH_WIDTH-1:0] depth;
   logic [16:0]                     mm;
   logic signed [18:0]              depth_s;
   logic signed [36:0]              frac_rhs;
   logic signed [36:0]              frac_lhs;
   logic                            post_ok, min_fail, max_fail, frac_fail;

   assign cnt[0] = item.count_a;
   assign cnt[1] = item.count_c;
   assign cnt[2] = item.count_g;
   assign cnt[3] = item.count_t;

   // strict compares so that a tie keeps the earlier genotype
   always_comb begin
      if (item.post_het > item.post_hom_major) begin
         best_01 = item.post_het;
         geno_01 = gcf_pkg::GENO_HET;
      end else begin
         best_01 = item.post_hom_major;
         geno_01 = gcf_pkg::GENO_HOM_MAJOR;
      end
      if (item.post_hom_minor > best_01) begin
         best = item.post_hom_minor;
         geno = gcf_pkg::GENO_HOM_MINOR;
      end else begin
         best = best_01;
         geno = geno_01;
      end
   end

   assign post_ok = best > cfg.post_cutoff;

   assign depth = 18'(cnt[0]) + 18'(cnt[1]) + 18'(cnt[2]) + 18'(cnt[3]);
   assign mm    = 17'(cnt[item.major_base]) + 17'(cnt[item.minor_base]);

   assign depth_s = $signed({1'b0, depth});

   assign min_fail = (cfg.min_depth != gcf_pkg::DEPTH_OFF) && (depth_s < cfg.min_depth);
   assign max_fail = (cfg.max_depth != gcf_pkg::DEPTH_OFF) && (depth_s > cfg.max_depth);

   // mm scaled by 2^16 against threshold times depth, all signed
   assign frac_lhs  = $signed({4'd0, mm, 16'd0});
   assign frac_rhs  = 37'(cfg.min_mm_fraction) * 37'(depth_s);
   assign frac_fail = (cfg.min_mm_fraction != gcf_pkg::FRACTION_OFF) && (frac_lhs < frac_rhs);

   assign call.called   = post_ok && !min_fail && !max_fail && !frac_fail
                          && item.site_selected;
   assign call.genotype = call.called ? geno : gcf_pkg::GENO_NONE;

endmodule

### design/gcf_site_tally.sv
// gcf_site_tally: per-site count of called individuals and the keep verdict
// depends on gcf_pkg
`timescale 1ns / 1ps

module gcf_site_tally (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        called,
   input  logic        selected,
   input  logic        last,
   input  logic [15:0] min_individuals,
   output logic        keep
);

   logic [gcf_pkg::CountWidth-1:0] count_ff, count_in, count_next;

   // saturating increment
   assign count_next = (called && count_ff != gcf_pkg::COUNT_MAX)
                       ? count_ff + 1'b1 : count_ff;

   assign keep = last && selected && (count_next != '0)
                 && (32'(count_next) >= 32'(min_individuals));

   always_comb begin
      count_in = count_ff;
      if (step) begin
         count_in = last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last |=> count_ff == '0)
      else $error("called count not cleared after last individual");

endmodule

### design/genotype_call_filter.sv
// genotype_call_filter: top level, input register, result register and apb registers
// depends on gcf_pkg, gcf_csr, gcf_call_unit, gcf_site_tally
`timescale 1ns / 1ps

// Calls one genotype per individual per site: picks the largest of three Q0.16
// posteriors (ties go to the earlier genotype) and reports -1 when the posterior,
// depth or major-plus-minor fraction checks fail or the site is unselected. The
// last individual of a site carries the keep verdict. One transaction is taken
// every cycle unless the output stalls; each passes the input register, then the
// call logic and one 18x19 multiply into the result register. The user must write
// thresholds via the apb port only while no transaction is in flight (unenforced).
module genotype_call_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [16:0]                    req_post_hom_major,
   input  logic [16:0]                    req_post_het,
   input  logic [16:0]                    req_post_hom_minor,
   input  logic [15:0]                    req_count_a,
   input  logic [15:0]                    req_count_c,
   input  logic [15:0]                    req_count_g,
   input  logic [15:0]                    req_count_t,
   input  logic [1:0]                     req_major_base,
   input  logic [1:0]                     req_minor_base,
   input  logic                           req_site_selected,
   input  logic                           req_last_individual,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [2:0]              rsp_genotype,
   output logic                           rsp_keep_site,
   output logic                           rsp_last_out,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gcf_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [gcf_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [gcf_pkg::DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   gcf_pkg::gcf_cfg_type  cfg;
   gcf_pkg::gcf_item_type req_item;
   gcf_pkg::gcf_item_type item_ff, item_in;
   gcf_pkg::gcf_call_type call;
   logic                  item_valid_ff, item_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [2:0]     geno_ff, geno_in;
   logic                  keep_ff, keep_in;
   logic                  last_ff, last_in;
   logic                  req_take, out_load, keep;

   gcf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_item.post_hom_major  = req_post_hom_major;
   assign req_item.post_het        = req_post_het;
   assign req_item.post_hom_minor  = req_post_hom_minor;
   assign req_item.count_a         = req_count_a;
   assign req_item.count_c         = req_count_c;
   assign req_item.count_g         = req_count_g;
   assign req_item.count_t         = req_count_t;
   assign req_item.major_base      = req_major_base;
   assign req_item.minor_base      = req_minor_base;
   assign req_item.site_selected   = req_site_selected;
   assign req_item.last_individual = req_last_individual;

   // result register frees when empty or being taken this cycle
   assign out_load  = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || out_load;
   assign req_take  = req_valid && req_ready;

   gcf_call_unit u_call (
      .item (item_ff),
      .cfg  (cfg),
      .call (call)
   );

   gcf_site_tally u_tally (
      .clock           (clock),
      .reset           (reset),
      .step            (out_load),
      .called          (call.called),
      .selected        (item_ff.site_selected),
      .last            (item_ff.last_individual),
      .min_individuals (cfg.min_individuals),
      .keep            (keep)
   );

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_in       = req_item;
         item_valid_in = 1'b1;
      end else if (out_load) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      geno_in      = geno_ff;
      keep_in      = keep_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         geno_in      = call.genotype;
         keep_in      = keep;
         last_in      = item_ff.last_individual;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      geno_ff <= geno_in;
      keep_ff <= keep_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_genotype  = geno_ff;
   assign rsp_keep_site = keep_ff;
   assign rsp_last_out  = last_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded result not presented");

   a_keep_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_out |-> !rsp_keep_site)
      else $error("keep flagged on a non-final individual");

   a_geno_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_genotype != 3'sd3 && rsp_genotype != -3'sd2
                    && rsp_genotype != -3'sd3 && rsp_genotype != -3'sd4)
      else $error("genotype outside its codes");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req_ready)
      else $error("empty input register refuses a transaction");

endmodule
